### rtl/i2cbs_pkg.sv
// Package with the shared types, command codes and helpers of the I2C master bit sequencer.
package i2cbs_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_TX_ACK = 3'd5;
    localparam logic [2:0] CMD_RX_ACK = 3'd6;
    localparam logic [2:0] CMD_RSVD   = 3'd7;

    // Sequence lengths in pin actions.
    localparam logic [4:0] LEN_START  = 5'd4;
    localparam logic [4:0] LEN_STOP   = 5'd3;
    localparam logic [4:0] LEN_WRITE  = 5'd24;
    localparam logic [4:0] LEN_READ   = 5'd25;
    localparam logic [4:0] LEN_TX_ACK = 5'd3;
    localparam logic [4:0] LEN_RX_ACK = 5'd4;

    // Configuration register map.
    localparam int          APB_ADDR_W      = 3;
    localparam logic [15:0] STEP_TICKS_RST  = 16'd1000;
    localparam logic [APB_ADDR_W-1:0] ADDR_STEP_TICKS = 3'd0;

    // Input word.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } out_word_t;

    // Sequencer state.
    typedef struct packed {
        logic [2:0]  active_cmd;
        logic [4:0]  action_idx;
        logic [15:0] wait_cnt;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic        ack_sampled;
        logic        scl_drive;
        logic        sda_drive;
    } seq_state_t;

    // Number of pin actions in a command's sequence.
    function automatic logic [4:0] seq_length(input logic [2:0] c);
        logic [4:0] len;
        case (c)
            CMD_START:  len = LEN_START;
            CMD_STOP:   len = LEN_STOP;
            CMD_WRITE:  len = LEN_WRITE;
            CMD_READ:   len = LEN_READ;
            CMD_TX_ACK: len = LEN_TX_ACK;
            CMD_RX_ACK: len = LEN_RX_ACK;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    // Remainder by three of a 5-bit index; the quotient is idx*11 >> 5,
    // exact for every value below 32.
    function automatic logic [1:0] mod3(input logic [4:0] idx);
        logic [8:0] prod;
        logic [3:0] quot;
        logic [5:0] three_q;
        logic [5:0] rem;
        prod    = {4'd0, idx} * 9'd11;
        quot    = prod[8:5];
        three_q = {2'd0, quot} + {1'b0, quot, 1'b0};
        rem     = {1'b0, idx} - three_q;
        return rem[1:0];
    endfunction

endpackage

### rtl/i2cbs_step.sv
// Next-state logic of the sequencer for one tick.
module i2cbs_step
    import i2cbs_pkg::*;
(
    input  seq_state_t  cur,
    input  in_word_t    din,
    input  logic [15:0] step_ticks,
    output seq_state_t  nxt,
    output logic        done
);

    logic [15:0] step_val;
    logic [15:0] wait_dec;
    logic        perf_en;
    logic [2:0]  perf_cmd;
    logic [4:0]  perf_idx;
    logic [1:0]  ph_wr;
    logic [1:0]  ph_rd;
    logic [4:0]  idx_m1;

    // A step of zero ticks behaves as one.
    assign step_val = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
    assign wait_dec = (cur.wait_cnt != 16'd0) ? cur.wait_cnt - 16'd1 : cur.wait_cnt;
    assign idx_m1   = perf_idx - 5'd1;
    assign ph_wr    = mod3(perf_idx);
    assign ph_rd    = mod3(idx_m1);

    always_comb begin
        nxt      = cur;
        done     = 1'b0;
        perf_en  = 1'b0;
        perf_cmd = cur.active_cmd;
        perf_idx = cur.action_idx;

        // Start a command when idle, or advance the running one.
        if (cur.active_cmd == CMD_NONE) begin
            if (din.cmd != CMD_NONE && din.cmd != CMD_RSVD) begin
                nxt.active_cmd = din.cmd;
                if (din.cmd == CMD_WRITE) begin
                    nxt.tx_shift = din.tx_byte;
                end else if (din.cmd == CMD_TX_ACK) begin
                    nxt.tx_shift = {din.ack_out, 7'd0};
                end
                if (din.cmd == CMD_READ) begin
                    nxt.rx_shift = 8'd0;
                end
                perf_en        = 1'b1;
                perf_cmd       = din.cmd;
                perf_idx       = 5'd0;
                nxt.action_idx = 5'd1;
                nxt.wait_cnt   = step_val;
            end
        end else begin
            nxt.wait_cnt = wait_dec;
            if (wait_dec == 16'd0) begin
                if (cur.action_idx < seq_length(cur.active_cmd)) begin
                    perf_en        = 1'b1;
                    nxt.action_idx = cur.action_idx + 5'd1;
                    nxt.wait_cnt   = step_val;
                end else begin
                    nxt.active_cmd = CMD_NONE;
                    nxt.action_idx = 5'd0;
                    done           = 1'b1;
                end
            end
        end

        // Pin action selected by command and index.
        if (perf_en) begin
            case (perf_cmd)
                CMD_START: begin
                    case (perf_idx)
                        5'd0:    nxt.sda_drive = 1'b1;
                        5'd1:    nxt.scl_drive = 1'b1;
                        5'd2:    nxt.sda_drive = 1'b0;
                        default: nxt.scl_drive = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (perf_idx)
                        5'd0:    nxt.sda_drive = 1'b0;
                        5'd1:    nxt.scl_drive = 1'b1;
                        default: nxt.sda_drive = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    case (ph_wr)
                        2'd0:    nxt.sda_drive = nxt.tx_shift[7];
                        2'd1:    nxt.scl_drive = 1'b1;
                        default: begin
                            nxt.scl_drive = 1'b0;
                            nxt.tx_shift  = {nxt.tx_shift[6:0], 1'b0};
                        end
                    endcase
                end
                CMD_READ: begin
                    if (perf_idx == 5'd0) begin
                        nxt.sda_drive = 1'b1;
                    end else begin
                        case (ph_rd)
                            2'd0:    nxt.scl_drive = 1'b1;
                            2'd1:    nxt.rx_shift  = {nxt.rx_shift[6:0], din.sda_in};
                            default: nxt.scl_drive = 1'b0;
                        endcase
                    end
                end
                CMD_TX_ACK: begin
                    case (perf_idx)
                        5'd0:    nxt.sda_drive = nxt.tx_shift[7];
                        5'd1:    nxt.scl_drive = 1'b1;
                        default: nxt.scl_drive = 1'b0;
                    endcase
                end
                CMD_RX_ACK: begin
                    case (perf_idx)
                        5'd0:    nxt.sda_drive   = 1'b1;
                        5'd1:    nxt.scl_drive   = 1'b1;
                        5'd2:    nxt.ack_sampled = din.sda_in;
                        default: nxt.scl_drive   = 1'b0;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: state, result register and APB register.
//
//  channel   direction  handshake                  word
//  s_        in         s_valid / s_ready          in_word_t (one tick)
//  m_        out        m_valid / m_ready          out_word_t (one per tick)
//  apb       in/out     psel, penable, pready      step_ticks at offset 0
//
// A word is accepted in each cycle in which the result register is empty or being
// drained, so throughput is one word per cycle; the result word is registered and
// valid in the cycle after. The path is set by the next-state logic between
// the sequencer state and the result register. Reset (aresetn low, synchronous)
// returns the lines to released, the sequencer to idle and step_ticks to 1000.
// A stall on m_ready stalls s_ready in the same cycle.
module i2c_master_bit_sequencer_core
    import i2cbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        done_next;
    logic [15:0] step_ticks_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;
    logic        s_accept;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STEP_TICKS) ? {16'd0, step_ticks_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg <= STEP_TICKS_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_STEP_TICKS) begin
            step_ticks_reg <= pwdata[15:0];
        end
    end

    // Handshake: take a word whenever the result register can be refilled.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    i2cbs_step u_step (
        .cur        (state_reg),
        .din        (s_data),
        .step_ticks (step_ticks_reg),
        .nxt        (state_next),
        .done       (done_next)
    );

    // Sequencer state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.active_cmd  <= CMD_NONE;
            state_reg.action_idx  <= 5'd0;
            state_reg.wait_cnt    <= 16'd0;
            state_reg.tx_shift    <= 8'd0;
            state_reg.rx_shift    <= 8'd0;
            state_reg.ack_sampled <= 1'b1;
            state_reg.scl_drive   <= 1'b1;
            state_reg.sda_drive   <= 1'b1;
            m_valid_reg           <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, taken from the updated state.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.scl_level   <= state_next.scl_drive;
            m_data_reg.sda_release <= state_next.sda_drive;
            m_data_reg.busy_res    <= (state_next.active_cmd != CMD_NONE);
            m_data_reg.done_res    <= done_next;
            m_data_reg.rx_byte     <= state_next.rx_shift;
            m_data_reg.ack_in      <= state_next.ack_sampled;
        end
    end

    // A finished sequence never reports busy in the same word.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done reported together with busy");

    // Idle state always has a cleared action index.
    a_idle_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.active_cmd == CMD_NONE |-> state_reg.action_idx == 5'd0)
        else $error("idle sequencer with nonzero action index");

    // A running command always has a pending wait.
    a_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.active_cmd != CMD_NONE |-> state_reg.wait_cnt != 16'd0)
        else $error("running command with empty wait counter");

    // The action index never runs past the longest sequence.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.action_idx <= LEN_READ)
        else $error("action index out of range");

    // A valid command taken while idle starts a sequence.
    a_cmd_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg.active_cmd == CMD_NONE && s_data.cmd != CMD_NONE
            && s_data.cmd != CMD_RSVD |=> state_reg.active_cmd != CMD_NONE)
        else $error("command accepted while idle did not start");

endmodule

### bench/i2c_master_bit_sequencer_core_tb.sv
// Self-checking testbench for the I2C master bit sequencer core, with an in-bench line predictor.
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_core_tb;
    import i2cbs_pkg::*;

    // Source of the sampled SDA level for the ticks sent to the block.
    typedef enum {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_t;

    // Scoreboard: tracks the sequencer state for every accepted tick and
    // checks each result word against the oldest predicted line state.
    class sequencer_scoreboard_t;
        logic [15:0] step_cfg;
        logic [2:0]  cur_cmd;
        logic [4:0]  act_idx;
        logic [15:0] wait_left;
        logic [7:0]  tx_sr;
        logic [7:0]  rx_sr;
        logic        ack_bit;
        logic        scl_q;
        logic        sda_q;
        out_word_t   expected_lines[$];
        int          fail_count;
        int          noted_ticks;

        function new();
            step_cfg    = STEP_TICKS_RST;
            cur_cmd     = CMD_NONE;
            act_idx     = '0;
            wait_left   = '0;
            tx_sr       = '0;
            rx_sr       = '0;
            ack_bit     = 1'b1;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            fail_count  = 0;
            noted_ticks = 0;
        endfunction

        function bit seq_busy();
            return cur_cmd != CMD_NONE;
        endfunction

        // A step of zero behaves as a step of one.
        function logic [15:0] reload();
            return (step_cfg == 16'd0) ? 16'd1 : step_cfg;
        endfunction

        function int action_count(input logic [2:0] c);
            case (c)
                CMD_START:  return LEN_START;
                CMD_STOP:   return LEN_STOP;
                CMD_WRITE:  return LEN_WRITE;
                CMD_READ:   return LEN_READ;
                CMD_TX_ACK: return LEN_TX_ACK;
                CMD_RX_ACK: return LEN_RX_ACK;
                default:    return 0;
            endcase
        endfunction

        // One pin action of a command's sequence.
        function void pin_action(input logic [2:0] c, input int idx, input logic sda);
            int ph;
            case (c)
                CMD_START: begin
                    if (idx == 0) sda_q = 1'b1;
                    else if (idx == 1) scl_q = 1'b1;
                    else if (idx == 2) sda_q = 1'b0;
                    else scl_q = 1'b0;
                end
                CMD_STOP: begin
                    if (idx == 0) sda_q = 1'b0;
                    else if (idx == 1) scl_q = 1'b1;
                    else sda_q = 1'b1;
                end
                CMD_WRITE: begin
                    ph = idx % 3;
                    if (ph == 0) sda_q = tx_sr[7];
                    else if (ph == 1) scl_q = 1'b1;
                    else begin
                        scl_q = 1'b0;
                        tx_sr = {tx_sr[6:0], 1'b0};
                    end
                end
                CMD_READ: begin
                    if (idx == 0) sda_q = 1'b1;
                    else begin
                        ph = (idx - 1) % 3;
                        if (ph == 0) scl_q = 1'b1;
                        else if (ph == 1) rx_sr = {rx_sr[6:0], sda};
                        else scl_q = 1'b0;
                    end
                end
                CMD_TX_ACK: begin
                    if (idx == 0) sda_q = tx_sr[7];
                    else if (idx == 1) scl_q = 1'b1;
                    else scl_q = 1'b0;
                end
                CMD_RX_ACK: begin
                    if (idx == 0) sda_q = 1'b1;
                    else if (idx == 1) scl_q = 1'b1;
                    else if (idx == 2) ack_bit = sda;
                    else scl_q = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Advance the state by one accepted tick and queue the line state it yields.
        function void note_tick(input in_word_t w);
            out_word_t e;
            logic      done;
            done = 1'b0;
            noted_ticks++;
            if (cur_cmd == CMD_NONE) begin
                if (w.cmd != CMD_NONE && w.cmd != CMD_RSVD) begin
                    cur_cmd = w.cmd;
                    if (w.cmd == CMD_WRITE) tx_sr = w.tx_byte;
                    else if (w.cmd == CMD_TX_ACK) tx_sr = {w.ack_out, 7'd0};
                    if (w.cmd == CMD_READ) rx_sr = '0;
                    pin_action(w.cmd, 0, w.sda_in);
                    act_idx   = 5'd1;
                    wait_left = reload();
                end
            end else begin
                if (wait_left != 16'd0) wait_left--;
                if (wait_left == 16'd0) begin
                    if (act_idx < action_count(cur_cmd)) begin
                        pin_action(cur_cmd, act_idx, w.sda_in);
                        act_idx++;
                        wait_left = reload();
                    end else begin
                        cur_cmd = CMD_NONE;
                        act_idx = '0;
                        done    = 1'b1;
                    end
                end
            end
            e.scl_level   = scl_q;
            e.sda_release = sda_q;
            e.busy_res    = (cur_cmd != CMD_NONE);
            e.done_res    = done;
            e.rx_byte     = rx_sr;
            e.ack_in      = ack_bit;
            expected_lines.push_back(e);
        endfunction

        function void report(input string name, input logic [7:0] exp, input logic [7:0] act);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            fail_count++;
        endfunction

        // Compare one result word with the oldest expectation, field by field.
        function void check_lines(input out_word_t got);
            out_word_t e;
            if (expected_lines.size() == 0) begin
                $display("%0t: result word with no expectation, actual %h", $time, got);
                fail_count++;
                return;
            end
            e = expected_lines.pop_front();
            if (got.scl_level !== e.scl_level) report("scl_level", e.scl_level, got.scl_level);
            if (got.sda_release !== e.sda_release)
                report("sda_release", e.sda_release, got.sda_release);
            if (got.busy_res !== e.busy_res) report("busy_res", e.busy_res, got.busy_res);
            if (got.done_res !== e.done_res) report("done_res", e.done_res, got.done_res);
            if (got.rx_byte !== e.rx_byte) report("rx_byte", e.rx_byte, got.rx_byte);
            if (got.ack_in !== e.ack_in) report("ack_in", e.ack_in, got.ack_in);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    sequencer_scoreboard_t sb;
    sda_mode_t             sda_mode = SDA_RANDOM;
    bit                    calm = 1'b0;
    int                    stall_left = 0;

    i2c_master_bit_sequencer_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Result side: random stalls on m_ready.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!calm) stall_left <= gap_len();
        end
    end

    // Check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_lines(m_data);
    end

    function automatic in_word_t make_tick(input logic [2:0] c, input logic [7:0] txb,
                                           input logic ackb);
        in_word_t w;
        w.cmd     = c;
        w.tx_byte = txb;
        w.ack_out = ackb;
        case (sda_mode)
            SDA_LOW:  w.sda_in = 1'b0;
            SDA_HIGH: w.sda_in = 1'b1;
            default:  w.sda_in = 1'($urandom);
        endcase
        return w;
    endfunction

    // Send one tick word and wait for its acceptance, then idle for a while.
    task automatic send_tick(input in_word_t w);
        int gap;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(w);
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Offer a command, then keep ticking until the sequence is over. With
    // pester set, every tick while busy carries a command that must be ignored.
    task automatic issue_cmd(input logic [2:0] c, input logic [7:0] txb, input logic ackb,
                             input bit pester);
        logic [2:0] filler;
        send_tick(make_tick(c, txb, ackb));
        while (sb.seq_busy()) begin
            filler = CMD_NONE;
            if (pester || $urandom_range(0, 19) == 0) filler = 3'($urandom_range(1, 7));
            send_tick(make_tick(filler, 8'($urandom), 1'($urandom)));
        end
    endtask

    // Bring the block to idle: sequence done and every result word drained.
    task automatic settle_block();
        while (sb.seq_busy()) send_tick(make_tick(CMD_NONE, 8'($urandom), 1'($urandom)));
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_lines.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write of step_ticks; the upper half of the data is junk.
    task automatic write_step(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STEP_TICKS;
        pwdata  <= {16'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.step_cfg = v;
    endtask

    // APB read of step_ticks, compared with the reset value or the value the bench last wrote.
    task automatic check_step_read();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_STEP_TICKS;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {16'd0, sb.step_cfg}) begin
            $display("%0t: step_ticks read mismatch, expected %0h, actual %0h", $time,
                     {16'd0, sb.step_cfg}, prdata);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A well-formed bus transaction with random content.
    task automatic run_transaction();
        logic [7:0] addr;
        int         n;
        bit         p;
        p    = ($urandom_range(0, 9) == 0);
        addr = 8'($urandom);
        n    = $urandom_range(0, 2);
        issue_cmd(CMD_START, 8'($urandom), 1'($urandom), p);
        issue_cmd(CMD_WRITE, addr, 1'($urandom), p);
        issue_cmd(CMD_RX_ACK, 8'($urandom), 1'($urandom), p);
        for (int i = 0; i < n; i++) begin
            if (addr[0]) begin
                issue_cmd(CMD_READ, 8'($urandom), 1'($urandom), p);
                issue_cmd(CMD_TX_ACK, 8'($urandom), (i == n - 1), p);
            end else begin
                issue_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), p);
                issue_cmd(CMD_RX_ACK, 8'($urandom), 1'($urandom), p);
            end
        end
        issue_cmd(CMD_STOP, 8'($urandom), 1'($urandom), p);
    endtask

    // Stimulus.
    initial begin
        logic [15:0] phase_steps[5];
        int          target;
        sb = new();
        phase_steps = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
        phase_steps[4] = 16'($urandom_range(1, 2));
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Step count after reset.
        check_step_read();

        // Directed commands at a zero step, which must act as one.
        write_step(16'd0);
        issue_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
        issue_cmd(CMD_WRITE, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_LOW;
        issue_cmd(CMD_RX_ACK, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_RANDOM;
        issue_cmd(CMD_WRITE, 8'hFF, 1'b1, 1'b0);
        sda_mode = SDA_HIGH;
        issue_cmd(CMD_RX_ACK, 8'hFF, 1'b1, 1'b0);
        sda_mode = SDA_RANDOM;
        issue_cmd(CMD_WRITE, 8'h5A, 1'b0, 1'b1);
        sda_mode = SDA_HIGH;
        issue_cmd(CMD_READ, 8'h00, 1'b0, 1'b0);
        issue_cmd(CMD_TX_ACK, 8'h00, 1'b0, 1'b0);
        sda_mode = SDA_LOW;
        issue_cmd(CMD_READ, 8'hFF, 1'b1, 1'b1);
        issue_cmd(CMD_TX_ACK, 8'h00, 1'b1, 1'b0);
        sda_mode = SDA_RANDOM;
        issue_cmd(CMD_READ, 8'h3C, 1'b1, 1'b0);
        issue_cmd(CMD_RSVD, 8'hFF, 1'b1, 1'b0);
        issue_cmd(CMD_NONE, 8'hFF, 1'b1, 1'b0);
        issue_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0);
        issue_cmd(CMD_STOP, 8'hFF, 1'b1, 1'b1);
        issue_cmd(CMD_RX_ACK, 8'h81, 1'b0, 1'b0);
        issue_cmd(CMD_TX_ACK, 8'hFF, 1'b0, 1'b1);
        settle_block();

        // Random phases, mostly well-formed transactions, some noise.
        foreach (phase_steps[k]) begin
            write_step(phase_steps[k]);
            target = sb.noted_ticks + 110;
            while (sb.noted_ticks < target) begin
                calm = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 99) < 80) run_transaction();
                else begin
                    repeat ($urandom_range(1, 3))
                        issue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                                  $urandom_range(0, 3) == 0);
                end
            end
            calm = 1'b0;
            settle_block();
        end

        // Largest step: a stop sequence, checked over its first ticks while
        // stray commands must be ignored.
        write_step(16'hFFFF);
        check_step_read();
        send_tick(make_tick(CMD_STOP, 8'($urandom), 1'($urandom)));
        repeat (40)
            send_tick(make_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom)));
        s_valid <= 1'b0;
        @(posedge aclk);

        // Drain and report.
        while (sb.expected_lines.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.fail_count == 0 && sb.expected_lines.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
